### rtl/wfp_pkg.sv
// ----------------------------------------------------------------------------
// wfp_pkg: shared types and constants for the wall following PD steering block
// Field widths, register indexes, result case codes and the structs that
// travel between the configuration bank, the datapath and the top level.
// ----------------------------------------------------------------------------
package wfp_pkg;

    localparam int DIST_W     = 12;
    localparam int TARGET_W   = 9;
    localparam int SPEED_W    = 15;
    localparam int TURN_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // side readings at or above this are out of range
    localparam int SIDE_LIMIT = 300;

    // register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOLLOW_RIGHT   = 3'd0,
        REG_TARGET_DIST    = 3'd1,
        REG_BASE_SPEED     = 3'd2,
        REG_MAX_TURN       = 3'd3,
        REG_PROP_GAIN      = 3'd4,
        REG_DERIV_GAIN     = 3'd5,
        REG_FRONT_STOP     = 3'd6
    } reg_index_t;

    // which branch produced a result
    typedef enum logic [1:0] {
        CASE_TRACK         = 2'd0,
        CASE_SIDE_INVALID  = 2'd1,
        CASE_FRONT_BLOCKED = 2'd2
    } case_t;

    typedef struct packed {
        logic                  follow_right;
        logic [TARGET_W-1:0]   target_distance;
        logic [SPEED_W-1:0]    base_speed;
        logic [SPEED_W-1:0]    max_turn;
        logic [GAIN_W-1:0]     prop_gain;
        logic [GAIN_W-1:0]     deriv_gain;
        logic [DIST_W-1:0]     front_stop_distance;
    } cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0] left_distance;
        logic [DIST_W-1:0] right_distance;
        logic [DIST_W-1:0] front_distance;
    } sample_t;

    typedef struct packed {
        logic [SPEED_W-1:0]       forward_speed;
        logic signed [TURN_W-1:0] turn_rate;
        case_t                    case_taken;
    } result_t;

endpackage

### rtl/wfp_if.sv
// ----------------------------------------------------------------------------
// wfp_if: channel interfaces for the wall following PD steering block
// Sensor input channel, steering command channel and configuration write
// channel, each with valid, ready and payload and a source and sink modport.
// ----------------------------------------------------------------------------
interface wfp_sensor_if;
    logic                         valid;
    logic                         ready;
    logic [wfp_pkg::DIST_W-1:0]   left_distance;
    logic [wfp_pkg::DIST_W-1:0]   right_distance;
    logic [wfp_pkg::DIST_W-1:0]   front_distance;

    modport source (output valid, output left_distance, output right_distance,
                    output front_distance, input ready);
    modport sink   (input valid, input left_distance, input right_distance,
                    input front_distance, output ready);
endinterface

interface wfp_command_if;
    logic                                valid;
    logic                                ready;
    logic [wfp_pkg::SPEED_W-1:0]         forward_speed;
    logic signed [wfp_pkg::TURN_W-1:0]   turn_rate;
    logic [1:0]                          case_taken;

    modport source (output valid, output forward_speed, output turn_rate,
                    output case_taken, input ready);
    modport sink   (input valid, input forward_speed, input turn_rate,
                    input case_taken, output ready);
endinterface

interface wfp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [wfp_pkg::CFG_IDX_W-1:0]    index;
    logic [wfp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/wfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// wfp_cfg_regs: configuration register bank
// Decodes writes on the configuration channel into the seven control
// registers; writes to unused indexes are taken and dropped.
// ----------------------------------------------------------------------------
module wfp_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    wfp_cfg_if.sink            cfg,
    output wfp_pkg::cfg_t      regs
);

    wfp_pkg::cfg_t regs_reg;
    wfp_pkg::cfg_t regs_next;

    // always take a write
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // decode the write index
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                wfp_pkg::REG_FOLLOW_RIGHT:
                    regs_next.follow_right = cfg.data[0];
                wfp_pkg::REG_TARGET_DIST:
                    regs_next.target_distance = cfg.data[wfp_pkg::TARGET_W-1:0];
                wfp_pkg::REG_BASE_SPEED:
                    regs_next.base_speed = cfg.data[wfp_pkg::SPEED_W-1:0];
                wfp_pkg::REG_MAX_TURN:
                    regs_next.max_turn = cfg.data[wfp_pkg::SPEED_W-1:0];
                wfp_pkg::REG_PROP_GAIN:
                    regs_next.prop_gain = cfg.data[wfp_pkg::GAIN_W-1:0];
                wfp_pkg::REG_DERIV_GAIN:
                    regs_next.deriv_gain = cfg.data[wfp_pkg::GAIN_W-1:0];
                wfp_pkg::REG_FRONT_STOP:
                    regs_next.front_stop_distance = cfg.data[wfp_pkg::DIST_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    // hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.follow_right        <= 1'b1;
            regs_reg.target_distance     <= wfp_pkg::TARGET_W'(20);
            regs_reg.base_speed          <= '0;
            regs_reg.max_turn            <= '0;
            regs_reg.prop_gain           <= '0;
            regs_reg.deriv_gain          <= '0;
            regs_reg.front_stop_distance <= wfp_pkg::DIST_W'(20);
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

### rtl/wfp_datapath.sv
// ----------------------------------------------------------------------------
// wfp_datapath: steering arithmetic for one sample
// Picks the followed side, forms the error and its change, chooses between
// the side invalid, front blocked and PD tracking cases, and clamps the turn.
// ----------------------------------------------------------------------------
module wfp_datapath (
    input  wfp_pkg::cfg_t                       cfg,
    input  wfp_pkg::sample_t                    sample,
    input  logic signed [wfp_pkg::ERR_W-1:0]    prev_error,
    output wfp_pkg::result_t                    result,
    output logic signed [wfp_pkg::ERR_W-1:0]    error,
    output logic                                track
);

    localparam int OP_W   = 11;
    localparam int PROD_W = wfp_pkg::GAIN_W + 1 + OP_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CLMP_W = SUM_W + 1;

    logic [wfp_pkg::DIST_W-1:0]        wall_dist;
    logic signed [wfp_pkg::ERR_W:0]    derr;
    logic                              wall_in_range;
    logic                              blocked;
    logic signed [PROD_W-1:0]          p_term;
    logic signed [PROD_W-1:0]          d_term;
    logic signed [SUM_W-1:0]           pd_sum;
    logic signed [CLMP_W-1:0]          pd_turn;
    logic signed [CLMP_W-1:0]          lim;
    logic signed [CLMP_W-1:0]          pd_clamped;
    logic signed [wfp_pkg::TURN_W-1:0] half_turn;
    logic signed [wfp_pkg::TURN_W-1:0] full_turn;

    // select side and form error terms
    assign wall_dist = cfg.follow_right ? sample.right_distance : sample.left_distance;
    assign error = $signed({2'b00, wall_dist})
                 - $signed({{(wfp_pkg::ERR_W-wfp_pkg::TARGET_W){1'b0}}, cfg.target_distance});
    assign derr  = $signed({error[wfp_pkg::ERR_W-1], error})
                 - $signed({prev_error[wfp_pkg::ERR_W-1], prev_error});

    // classify the sample
    assign wall_in_range = (wall_dist != '0)
                        && (wall_dist < wfp_pkg::DIST_W'(wfp_pkg::SIDE_LIMIT));
    assign blocked    = (sample.front_distance != '0)
                     && (sample.front_distance < cfg.front_stop_distance);
    assign track      = wall_in_range && !blocked;

    // PD products; both operands stay within 11 bits in the tracking case
    assign p_term = $signed({1'b0, cfg.prop_gain})  * $signed(error[OP_W-1:0]);
    assign d_term = $signed({1'b0, cfg.deriv_gain}) * $signed(derr[OP_W-1:0]);
    assign pd_sum = $signed({p_term[PROD_W-1], p_term}) + $signed({d_term[PROD_W-1], d_term});

    // steer against the error on the right side, with it on the left
    assign pd_turn = cfg.follow_right ? -$signed({pd_sum[SUM_W-1], pd_sum})
                                      :  $signed({pd_sum[SUM_W-1], pd_sum});
    assign lim     = $signed({{(CLMP_W-wfp_pkg::SPEED_W){1'b0}}, cfg.max_turn});

    // saturate to the turn limit
    always_comb
    begin
        if (pd_turn > lim)
            pd_clamped = lim;
        else if (pd_turn < -lim)
            pd_clamped = -lim;
        else
            pd_clamped = pd_turn;
    end

    assign half_turn = $signed({2'b00, cfg.max_turn[wfp_pkg::SPEED_W-1:1]});
    assign full_turn = $signed({1'b0, cfg.max_turn});

    // choose the case
    always_comb
    begin
        if (!wall_in_range)
        begin
            result.forward_speed = {1'b0, cfg.base_speed[wfp_pkg::SPEED_W-1:1]};
            result.turn_rate     = cfg.follow_right ? half_turn : -half_turn;
            result.case_taken    = wfp_pkg::CASE_SIDE_INVALID;
        end
        else if (blocked)
        begin
            result.forward_speed = '0;
            result.turn_rate     = cfg.follow_right ? -full_turn : full_turn;
            result.case_taken    = wfp_pkg::CASE_FRONT_BLOCKED;
        end
        else
        begin
            result.forward_speed = cfg.base_speed;
            result.turn_rate     = pd_clamped[wfp_pkg::TURN_W-1:0];
            result.case_taken    = wfp_pkg::CASE_TRACK;
        end
    end

endmodule

### rtl/wall_follow_pd_steering.sv
// ----------------------------------------------------------------------------
// wall_follow_pd_steering: PD wall following steering controller
// Turns left, right and front range readings into a forward speed and a
// clamped turn rate, tracking one stored error between samples.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      payload
//  -------   ---   ------------   ----------------------------------------------
//  sensor    in    valid/ready    left_distance, right_distance, front_distance
//  command   out   valid/ready    forward_speed, turn_rate, case_taken
//  cfg       in    valid/ready    index, data (ready always high)
//
//  Command valid rises once an accepted item has passed the input register,
//  then the datapath into the result register. One item per cycle is
//  sustained while command ready stays high; the stored error updates as a
//  tracking-case item moves into the result register. Reset clears the
//  stored error, the pipeline valids and the configuration registers to their
//  defaults. A stalled command holds its item while one more item waits in
//  the input register; sensor ready drops only when both are full.
//
module wall_follow_pd_steering (
    input  logic        clk,
    input  logic        rst_n,
    wfp_sensor_if.sink  sensor,
    wfp_command_if.source command,
    wfp_cfg_if.sink     cfg
);

    wfp_pkg::cfg_t                      cfg_regs;
    wfp_pkg::result_t                   dp_result;
    logic signed [wfp_pkg::ERR_W-1:0]   dp_error;
    logic                               dp_track;

    logic                               s1_valid_reg;
    wfp_pkg::sample_t                   s1_sample_reg;
    logic                               s2_valid_reg;
    wfp_pkg::result_t                   s2_result_reg;
    logic signed [wfp_pkg::ERR_W-1:0]   prev_error_reg;

    logic                               s2_load;
    logic                               s1_fire;
    logic                               sensor_fire;

    wfp_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    wfp_datapath u_datapath (
        .cfg        (cfg_regs),
        .sample     (s1_sample_reg),
        .prev_error (prev_error_reg),
        .result     (dp_result),
        .error      (dp_error),
        .track      (dp_track)
    );

    // pipeline flow control
    assign s2_load      = !s2_valid_reg || command.ready;
    assign s1_fire      = s1_valid_reg && s2_load;
    assign sensor.ready = !s1_valid_reg || s2_load;
    assign sensor_fire  = sensor.valid && sensor.ready;

    // advance valids and the stored error
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            prev_error_reg <= '0;
        end
        else
        begin
            if (sensor.ready)
                s1_valid_reg <= sensor.valid;
            if (s2_load)
                s2_valid_reg <= s1_valid_reg;
            if (s1_fire && dp_track)
                prev_error_reg <= dp_error;
        end
    end

    // capture payloads
    always_ff @(posedge clk)
    begin
        if (sensor_fire)
        begin
            s1_sample_reg.left_distance  <= sensor.left_distance;
            s1_sample_reg.right_distance <= sensor.right_distance;
            s1_sample_reg.front_distance <= sensor.front_distance;
        end
        if (s1_fire)
            s2_result_reg <= dp_result;
    end

    // drive the command channel
    assign command.valid         = s2_valid_reg;
    assign command.forward_speed = s2_result_reg.forward_speed;
    assign command.turn_rate     = s2_result_reg.turn_rate;
    assign command.case_taken    = s2_result_reg.case_taken;

    // the stored error moves only with an item leaving the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(prev_error_reg))
        else $error("stored error changed without an item advancing");

    // an accepted item lands in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        sensor_fire |=> s1_valid_reg)
        else $error("accepted item lost at the input register");

    // a pending command never exceeds the turn limit
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |->
            (s2_result_reg.turn_rate <= $signed({1'b0, cfg_regs.max_turn}))
            && (s2_result_reg.turn_rate >= -$signed({1'b0, cfg_regs.max_turn})))
        else $error("turn rate outside the turn limit");

endmodule
